// ===== sv/absrt_pkg.sv =====
// Shared types and constants for the ascending block sorter.
// No dependencies; used by absrt_cell and ascending_block_sorter_core.
package absrt_pkg;

  // Width of one sample
  localparam int unsigned DATA_W = 32;

  // Default number of sorting cells
  localparam int unsigned DEPTH_DEFAULT = 64;

  // Controller phases: collect the set, then stream it out
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } sorter_state_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast sample into its ordered position
    logic shift;   // move every value one cell towards the head
  } cell_ctrl_t;

endpackage

// ===== sv/absrt_cell.sv =====
// One cell of the insertion chain: holds a single sample of the ordered row.
// Depends on absrt_pkg for the data width and the cell command struct.
module absrt_cell (
  input  logic                                   clk,
  input  absrt_pkg::cell_ctrl_t                  ctrl,
  input  logic                                   occupied,   // cell holds a sample of this set
  input  logic signed [absrt_pkg::DATA_W-1:0]    sample,     // broadcast sample being inserted
  input  logic signed [absrt_pkg::DATA_W-1:0]    prev_value, // value of the cell towards the head
  input  logic                                   prev_keep,  // head-side cell keeps its value
  input  logic signed [absrt_pkg::DATA_W-1:0]    next_value, // value of the cell towards the tail
  output logic signed [absrt_pkg::DATA_W-1:0]    value,
  output logic                                   keep
);

  logic signed [absrt_pkg::DATA_W-1:0] value_next;

  // Keep own value when the cell is occupied and its value orders no later than the incoming sample
  assign keep = occupied && (value <= sample);

  // Select the new content: hold, take the sample, or take the neighbour's value
  always_comb begin
    value_next = value;
    if (ctrl.insert) begin
      if (!keep) begin
        value_next = prev_keep ? sample : prev_value;
      end
    end else if (ctrl.shift) begin
      value_next = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== sv/ascending_block_sorter_core.sv =====
// Ascending block sorter: a chain of insertion cells plus the set controller.
// Depends on absrt_pkg and instantiates absrt_cell DEPTH times.
//
//  Channel  | Direction | tdata                 | tlast     | tuser
//  s_axis   | in        | [31:0] sample_value   | final_item| -
//  m_axis   | out       | [31:0] sorted_value   | run_end   | [0] overflowed
//
// Collection: one sample per cycle; each request is placed into order by
// the cell chain in the cycle it is taken.
// Output: one sorted value per cycle from the head cell while m_axis_tready
// is high; the input stalls while a set drains (DEPTH stored values at most).
// Reset (rst, synchronous) empties the set; cell contents are not cleared.
// Samples arriving with the chain full are dropped and flag overflowed.
module ascending_block_sorter_core #(
  parameter int unsigned DEPTH = absrt_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
  input  logic        s_axis_tlast,   // final_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output logic        m_axis_tlast,   // run_end
  output logic [0:0]  m_axis_tuser    // [0] overflowed
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  absrt_pkg::sorter_state_t state, state_next;
  logic [CNT_W-1:0]         fill, fill_next;
  logic                     overflow, overflow_next;
  absrt_pkg::cell_ctrl_t    ctrl;

  logic in_req, out_req, room;

  logic signed [absrt_pkg::DATA_W-1:0] sample;
  logic signed [absrt_pkg::DATA_W-1:0] cell_value [DEPTH];
  logic                                cell_keep  [DEPTH];

  assign sample  = s_axis_tdata;
  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign out_req = m_axis_tvalid && m_axis_tready;
  assign room    = (fill != FULL);

  // Build the cell chain; head cell is index zero and holds the smallest value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic signed [absrt_pkg::DATA_W-1:0] prev_v, next_v;
    logic                                prev_k;

    if (i == 0) begin : g_head
      assign prev_v = sample;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_v = cell_value[i-1];
      assign prev_k = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_v = cell_value[i];
    end else begin : g_inner
      assign next_v = cell_value[i+1];
    end

    absrt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (IDX < fill),
      .sample     (sample),
      .prev_value (prev_v),
      .prev_keep  (prev_k),
      .next_value (next_v),
      .value      (cell_value[i]),
      .keep       (cell_keep[i])
    );
  end

  // Hold the phase, fill level and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= absrt_pkg::ST_FILL;
      fill     <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      overflow <= overflow_next;
    end
  end

  // Sequence collection and drain, and drive the chain commands
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    overflow_next = overflow;
    ctrl          = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state)
      absrt_pkg::ST_FILL: begin
        s_axis_tready = 1'b1;
        if (in_req) begin
          if (room) begin
            ctrl.insert = 1'b1;
            fill_next   = fill + ONE;
          end else begin
            overflow_next = 1'b1;
          end
          if (s_axis_tlast) begin
            state_next = absrt_pkg::ST_DRAIN;
          end
        end
      end
      absrt_pkg::ST_DRAIN: begin
        m_axis_tvalid = 1'b1;
        if (out_req) begin
          ctrl.shift = 1'b1;
          fill_next  = fill - ONE;
          if (fill == ONE) begin
            state_next    = absrt_pkg::ST_FILL;
            overflow_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = absrt_pkg::ST_FILL;
      end
    endcase
  end

  // Present the head cell as the next result
  assign m_axis_tdata    = cell_value[0];
  assign m_axis_tlast    = (fill == ONE);
  assign m_axis_tuser[0] = overflow;

  // Never take a request while a set drains
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken during drain");

  // A draining set is never empty
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (fill != '0))
    else $error("drain with empty chain");

  // Fill level stays within the chain
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill level beyond chain length");

  // Last result empties the set and clears the overflow flag
  a_set_end: assert property (@(posedge clk) disable iff (rst)
    (out_req && m_axis_tlast) |=> (fill == '0 && !overflow && s_axis_tready))
    else $error("set not closed after last result");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for ascending_block_sorter_core: streams signed sample sets in,
// predicts the ascending output of each set and checks every sorted request.
// Depends on absrt_pkg and the sorter RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_DEPTH = absrt_pkg::DEPTH_DEFAULT;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct {
    logic [31:0] value;
    logic        last;
    int unsigned gap;
  } sample_req_t;

  typedef struct {
    logic [31:0] value;
    logic        run_end;
    logic        overflowed;
  } sorted_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  sample_req_t   pending_samples[$];
  sorted_entry_t expected_sorted[$];
  sample_req_t   next_req;

  // predictor copy of the collected set
  logic [31:0] set_store [SET_DEPTH];
  int unsigned set_fill = 0;
  logic        set_dropped = 1'b0;

  int unsigned mismatches = 0;
  int unsigned gap_count = 0;
  int unsigned stall_left = 0;
  int unsigned results_taken = 0;
  int unsigned idle_cycles = 0;

  ascending_block_sorter_core #(
    .DEPTH(SET_DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 30) begin
      $display("%0t mismatch in %s: expected %0d got %0d", $realtime, what,
               $signed(want), $signed(got));
    end
  endtask

  // Store one sample; on the last one sort the set and queue its results
  function automatic void absorb_sample(logic [31:0] value, logic last);
    logic signed [31:0] ordered [SET_DEPTH];
    logic signed [31:0] key;
    int                 m;
    sorted_entry_t      entry;
    if (set_fill < SET_DEPTH) begin
      set_store[set_fill] = value;
      set_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    for (int k = 0; k < set_fill; k++) ordered[k] = set_store[k];
    for (int k = 1; k < set_fill; k++) begin
      key = ordered[k];
      m = k;
      while (m > 0 && key < ordered[m-1]) begin
        ordered[m] = ordered[m-1];
        m--;
      end
      ordered[m] = key;
    end
    for (int k = 0; k < set_fill; k++) begin
      entry.value = ordered[k];
      entry.run_end = (k + 1 == set_fill);
      entry.overflowed = set_dropped;
      expected_sorted.push_back(entry);
    end
    set_fill = 0;
    set_dropped = 1'b0;
  endfunction

  function automatic void push_sample(logic [31:0] value, logic last, int unsigned gap);
    sample_req_t req;
    req.value = value;
    req.last = last;
    req.gap = gap;
    pending_samples.push_back(req);
  endfunction

  function automatic logic [31:0] draw_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom();
    if (pick < 8) return 32'($signed($urandom_range(0, 8)) - 4);
    case ($urandom_range(0, 3))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Add one random set; gap-free sets give stretches without idling
  function automatic void push_random_set(int unsigned len);
    bit burst;
    burst = ($urandom_range(0, 2) == 0);
    for (int unsigned k = 0; k < len; k++) begin
      push_sample(draw_value(), k + 1 == len, burst ? 0 : $urandom_range(0, 8));
    end
  endfunction

  // Build the stimulus: directed sets first, then random sets
  initial begin
    int unsigned total;
    int unsigned len;
    int unsigned pick;
    // extremes, zero and both signs, with repeats
    push_sample(32'h7fff_ffff, 1'b0, 0);
    push_sample(32'h8000_0000, 1'b0, 0);
    push_sample(32'h0000_0000, 1'b0, 0);
    push_sample(32'hffff_ffff, 1'b0, 0);
    push_sample(32'h0000_0001, 1'b0, 0);
    push_sample(32'h8000_0000, 1'b0, 0);
    push_sample(32'h7fff_ffff, 1'b1, 0);
    // set made of its last item alone
    push_sample(32'h0000_0005, 1'b1, 0);
    // duplicates in every position
    push_sample(32'hffff_fffd, 1'b0, 0);
    push_sample(32'hffff_fffd, 1'b0, 0);
    push_sample(32'h0000_0002, 1'b0, 0);
    push_sample(32'h0000_0002, 1'b0, 0);
    push_sample(32'hffff_fffd, 1'b1, 0);
    // reversed pair and near-extreme values
    push_sample(32'd100, 1'b0, 0);
    push_sample(-32'sd100, 1'b1, 0);
    push_sample(32'h8000_0001, 1'b0, 1);
    push_sample(32'h7fff_fffe, 1'b0, 2);
    push_sample(32'hffff_fffe, 1'b0, 0);
    push_sample(32'h0000_0002, 1'b1, 3);
    // store exactly full, one dropped (the last itself), several dropped
    push_random_set(SET_DEPTH);
    push_random_set(SET_DEPTH + 1);
    push_random_set(SET_DEPTH + 6);
    total = pending_samples.size();
    while (total < 420) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) len = $urandom_range(1, 12);
      else if (pick < 18) len = $urandom_range(13, 40);
      else len = $urandom_range(SET_DEPTH - 2, SET_DEPTH + 4);
      push_random_set(len);
      total += len;
    end
  end

  // Hold reset from the start, then release it
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Drive samples from the pending queue, honouring each request's gap
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_count = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_samples.size() != 0 && gap_count >= pending_samples[0].gap) begin
        next_req = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= next_req.value;
        s_axis_tlast <= next_req.last;
        gap_count = 0;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (pending_samples.size() != 0) gap_count++;
      end
    end
  end

  // Feed every accepted sample request into the predictor
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      absorb_sample(s_axis_tdata, s_axis_tlast);
    end
  end

  // Receiver: random stalls per result, one long hold to back up the input
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_taken++;
        if (results_taken == 100) stall_left = LONG_HOLD;
        else if (results_taken % 80 < 24) stall_left = 0;
        else stall_left = $urandom_range(0, 8);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check each sorted request against the oldest expectation
  always @(posedge clk) begin
    sorted_entry_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_sorted.size() == 0) begin
        report_mismatch("unexpected result", '0, m_axis_tdata);
      end else begin
        want = expected_sorted.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch("sorted_value", want.value, m_axis_tdata);
        if (m_axis_tlast !== want.run_end)
          report_mismatch("run_end", 32'(want.run_end), 32'(m_axis_tlast));
        if (m_axis_tuser[0] !== want.overflowed)
          report_mismatch("overflowed", 32'(want.overflowed), 32'(m_axis_tuser[0]));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Wait for the stimulus and the results to drain, then decide
  initial begin
    @(negedge rst);
    while (pending_samples.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (SET_DEPTH + 16) @(posedge clk);
    if (expected_sorted.size() != 0) begin
      report_mismatch("results never delivered", 32'(expected_sorted.size()), '0);
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
